// File: rtl/assert_macros.svh
// Assertion macros shared by the modular arithmetic unit RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must stay stable in the cycle after a condition holds.
`define MAU_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/mau_pkg.sv
// Package for the modular arithmetic unit: opcodes, widths, reset modulus and register address.
// Used by the front end, the execution core and the top level.
package mau_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned ExpW = 63;
  localparam int unsigned ModResetVal = 1000000007;

  typedef enum logic [CmdW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4,
    OP_DIV = 3'd5,
    OP_NOP6 = 3'd6,
    OP_NOP7 = 3'd7
  } op_e;

  localparam logic [1:0] RegModulus = 2'd0;

endpackage

// File: rtl/mau_stream_if.sv
// Valid/ready stream interface carrying a payload of parameter width.
// Depends on nothing.
interface mau_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/modular_arithmetic_unit_top.sv
// Channel   Dir  Payload
// in_if     in   cmd(3) operand_a(RESIDUE_BITS) operand_b(63)
// out_if    out  result(RESIDUE_BITS)
// apb       in   modulus at address 0
// The front runs the bit-serial reduction and then pushes the entry into the queue.
// In the core, add, subtract and unused opcodes finish in the dispatch state; multiply,
// power, each Euclid round (a long division, then a multiplication) and divide, which adds
// one multiplication, all use the shared bit-serial multiplier.
// Reset is asynchronous and active low; either side may stall independently.
// Top level: APB register, front end, queue and execution core.
// Depends on mau_pkg, mau_stream_if, mau_front and mau_core.
module modular_arithmetic_unit_top #(
  parameter int unsigned RESIDUE_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mau_stream_if.sink   in_if,
  mau_stream_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mau_pkg::*;

  localparam int unsigned QW = 3 + 63 + 2 * RESIDUE_BITS;

  logic [RESIDUE_BITS-1:0] mod_q;
  logic          qv, qr;
  logic [QW-1:0] qd;

  assign pready = 1'b1;
  assign prdata = 32'(mod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= RESIDUE_BITS'(ModResetVal);
    end else if (psel && penable && pwrite && paddr == RegModulus) begin
      mod_q <= pwdata[RESIDUE_BITS-1:0];
    end
  end

  mau_front #(.RW(RESIDUE_BITS), .QW(QW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_cmd_i   (in_if.data[2:0]),
    .in_a_i     (in_if.data[3 +: RESIDUE_BITS]),
    .in_b_i     (in_if.data[3+RESIDUE_BITS +: 63]),
    .mod_i      (mod_q),
    .q_valid_o  (qv),
    .q_ready_i  (qr),
    .q_data_o   (qd)
  );

  mau_core #(.RW(RESIDUE_BITS), .QW(QW)) u_core (
    .clk_i, .rst_ni,
    .q_valid_i    (qv),
    .q_ready_o    (qr),
    .q_data_i     (qd),
    .mod_i        (mod_q),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_result_o (out_if.data)
  );
endmodule

// File: rtl/mau_front.sv
// Front end: accepts items, reduces residue operands modulo the modulus
// bit-serially and pushes a classified entry into a two-entry queue.
// Depends on mau_pkg.
module mau_front #(
  parameter int unsigned RW = 31,
  parameter int unsigned QW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    in_cmd_i,
  input  logic [RW-1:0] in_a_i,
  input  logic [62:0]   in_b_i,
  input  logic [RW-1:0] mod_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output logic [QW-1:0] q_data_o
);
  import mau_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RED, S_PUSH} st_e;

  st_e           st_q;
  logic [2:0]    cmd_q;
  logic [62:0]   b_raw_q;
  logic [62:0]   sh_q;
  logic [RW:0]   ra_q, rb_q;
  logic [5:0]    cnt_q;
  logic [RW-1:0] a_q;

  // Queue of two entries.
  logic [QW-1:0] qm_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt2_q;
  logic          push, pop;

  logic [RW:0] ra_sh, rb_sh, ra_nx, rb_nx;
  logic        mod_ok;

  assign mod_ok = (mod_i >= RW'(2));
  assign in_ready_o = (st_q == S_IDLE);
  assign push = (st_q == S_PUSH) && (cnt2_q != 2'd2);
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt2_q != 2'd0);
  assign q_data_o = qm_q[rp_q];

  always_comb begin
    // One restoring step of each reduction: shift in a bit, subtract if it fits.
    ra_sh = {ra_q[RW-1:0], a_q[RW-1]};
    rb_sh = {rb_q[RW-1:0], sh_q[62]};
    ra_nx = (ra_sh >= {1'b0, mod_i}) ? ra_sh - {1'b0, mod_i} : ra_sh;
    rb_nx = (rb_sh >= {1'b0, mod_i}) ? rb_sh - {1'b0, mod_i} : rb_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt2_q <= 2'd0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= in_cmd_i;
            b_raw_q <= in_b_i;
            sh_q    <= in_b_i;
            a_q     <= in_a_i;
            ra_q    <= '0;
            rb_q    <= '0;
            cnt_q   <= '0;
            st_q    <= S_RED;
          end
        end
        S_RED: begin
          sh_q  <= {sh_q[61:0], 1'b0};
          rb_q  <= rb_nx;
          cnt_q <= cnt_q + 6'd1;
          // a is walked from its top bit and is used up after RW steps.
          a_q   <= {a_q[RW-2:0], 1'b0};
          if (cnt_q < 6'(RW)) ra_q <= ra_nx;
          if (cnt_q == 6'd62) st_q <= S_PUSH;
        end
        S_PUSH: begin
          if (push) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt2_q <= cnt2_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      qm_q[wp_q] <= {mod_ok ? cmd_q : 3'(OP_NOP6), b_raw_q, rb_q[RW-1:0], ra_q[RW-1:0]};
    end
  end

  `include "assert_macros.svh"
  `MAU_ASSERT(a_qcnt, clk_i, rst_ni, cnt2_q != 2'd3, "front queue overflow")
  `MAU_ASSERT(a_push, clk_i, rst_ni, push |-> st_q == S_PUSH, "push outside push state")
  `MAU_ASSERT_HOLD(a_busy, clk_i, rst_ni, st_q == S_RED, cmd_q, "cmd changed in reduction")
endmodule

// File: rtl/mau_core.sv
// Execution core: bit-serial modular multiplier, square-and-multiply sequencer
// and a binary-long-division extended Euclid. Depends on mau_pkg.
module mau_core #(
  parameter int unsigned RW = 31,
  parameter int unsigned QW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  logic [QW-1:0] q_data_i,
  input  logic [RW-1:0] mod_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [RW-1:0] out_result_o
);
  import mau_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE, C_DISP, C_MUL, C_PSTEP, C_DIVS, C_EUPD, C_EFIN, C_DONE
  } st_e;

  st_e st_q;
  logic [2:0]    op_q;
  logic [62:0]   ex_q;
  logic [RW-1:0] ra_q, rb_q;
  logic [RW-1:0] acc_q, base_q;
  logic [RW-1:0] res_q;
  // The output register keeps a waiting result while the next item runs.
  logic [RW-1:0] out_q;
  logic          ov_q;
  // Multiplier: product = x*y mod m, one bit of y per cycle, MSB first.
  logic [RW-1:0] mx_q, my_q, mp_q;
  logic [5:0]    mc_q;
  logic [1:0]    mk_q; // 0 final or Euclid q*s1, 1 acc*base, 2 base*base, 3 a*inv
  // Euclid, signed coefficients kept modulo m as residues.
  logic [RW-1:0] g0_q, g1_q, s0_q, s1_q, qt_q, rem_q;
  logic [5:0]    dc_q;
  logic          esq_q; // multiply q*s1 pending

  logic [RW+1:0] dbl, dbl_r, add_r, sum2;
  logic [RW:0]   rsh;
  logic [RW+1:0] tsub;
  logic [RW:0]   sdiff;

  always_comb begin
    dbl   = {1'b0, mp_q, 1'b0};
    dbl_r = (dbl >= {2'b0, mod_i}) ? dbl - {2'b0, mod_i} : dbl;
    add_r = dbl_r + (my_q[RW-1] ? {2'b0, mx_q} : '0);
    sum2  = (add_r >= {2'b0, mod_i}) ? add_r - {2'b0, mod_i} : add_r;
    rsh   = {rem_q, g0_q[RW-1-dc_q[4:0]]};
    tsub  = {1'b0, rsh} - {2'b0, g1_q};
    sdiff = {1'b0, s0_q} + {1'b0, mod_i} - {1'b0, mp_q};
  end

  assign q_ready_o   = (st_q == C_IDLE);
  assign out_valid_o = ov_q;
  assign out_result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= C_IDLE;
      ov_q  <= 1'b0;
      out_q <= '0;
    end else begin
      if (st_q == C_DONE && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (st_q)
        C_IDLE: if (q_valid_i) begin
          op_q <= q_data_i[QW-1 -: 3];
          ex_q <= q_data_i[2*RW +: 63];
          rb_q <= q_data_i[RW +: RW];
          ra_q <= q_data_i[RW-1:0];
          st_q <= C_DISP;
        end
        C_DISP: begin
          case (op_q)
            3'(OP_ADD): begin
              res_q <= ({1'b0, ra_q} + {1'b0, rb_q} >= {1'b0, mod_i}) ?
                       RW'({1'b0, ra_q} + {1'b0, rb_q} - {1'b0, mod_i}) : ra_q + rb_q;
              st_q <= C_DONE;
            end
            3'(OP_SUB): begin
              res_q <= (ra_q >= rb_q) ? ra_q - rb_q : RW'({1'b0, ra_q} + {1'b0, mod_i}
                       - {1'b0, rb_q});
              st_q <= C_DONE;
            end
            3'(OP_MUL): begin
              mx_q <= ra_q; my_q <= rb_q; mp_q <= '0; mc_q <= '0; mk_q <= 2'd0;
              esq_q <= 1'b0;
              st_q <= C_MUL;
            end
            3'(OP_POW): begin
              acc_q <= RW'(1); base_q <= ra_q;
              st_q <= C_PSTEP;
            end
            3'(OP_INV), 3'(OP_DIV): begin
              g0_q <= rb_q; g1_q <= mod_i; s0_q <= RW'(1); s1_q <= '0;
              rem_q <= '0; qt_q <= '0; dc_q <= '0; esq_q <= 1'b0;
              st_q <= (mod_i == '0) ? C_EFIN : C_DIVS;
            end
            default: begin
              res_q <= '0;
              st_q <= C_DONE;
            end
          endcase
        end
        C_PSTEP: begin
          if (ex_q == '0) begin
            res_q <= acc_q; st_q <= C_DONE;
          end else if (ex_q[0]) begin
            mx_q <= acc_q; my_q <= base_q; mp_q <= '0; mc_q <= '0; mk_q <= 2'd1;
            st_q <= C_MUL;
          end else begin
            mx_q <= base_q; my_q <= base_q; mp_q <= '0; mc_q <= '0; mk_q <= 2'd2;
            st_q <= C_MUL;
          end
        end
        C_MUL: begin
          if (mc_q != 6'(RW-1)) begin
            mp_q <= sum2[RW-1:0];
            my_q <= {my_q[RW-2:0], 1'b0};
            mc_q <= mc_q + 6'd1;
          end else begin
            case (mk_q)
              2'd1: begin
                acc_q <= sum2[RW-1:0];
                mx_q <= base_q; my_q <= base_q; mp_q <= '0; mc_q <= '0; mk_q <= 2'd2;
              end
              2'd2: begin
                base_q <= sum2[RW-1:0]; ex_q <= {1'b0, ex_q[62:1]};
                st_q <= C_PSTEP;
              end
              2'd3: begin
                res_q <= sum2[RW-1:0]; st_q <= C_DONE;
              end
              default: begin
                if (esq_q) begin
                  mp_q <= sum2[RW-1:0]; st_q <= C_EUPD;
                end else begin
                  res_q <= sum2[RW-1:0]; st_q <= C_DONE;
                end
              end
            endcase
          end
        end
        C_DIVS: begin
          // g1 is nonzero here; divide g0 by g1 one quotient bit a cycle.
          if (g1_q == '0) begin
            st_q <= C_EFIN;
          end else begin
            rem_q <= tsub[RW+1] ? rsh[RW-1:0] : tsub[RW-1:0];
            qt_q  <= {qt_q[RW-2:0], ~tsub[RW+1]};
            dc_q  <= dc_q + 6'd1;
            if (dc_q == 6'(RW-1)) begin
              mx_q <= s1_q; my_q <= {qt_q[RW-2:0], ~tsub[RW+1]};
              mp_q <= '0; mc_q <= '0; mk_q <= 2'd0; esq_q <= 1'b1;
              st_q <= C_MUL;
            end
          end
        end
        C_EUPD: begin
          g0_q <= g1_q;
          g1_q <= rem_q;
          s0_q <= s1_q;
          s1_q <= (sdiff >= {1'b0, mod_i}) ? RW'(sdiff - {1'b0, mod_i}) : sdiff[RW-1:0];
          rem_q <= '0; qt_q <= '0; dc_q <= '0; esq_q <= 1'b0;
          st_q <= (rem_q == '0) ? C_EFIN : C_DIVS;
        end
        C_EFIN: begin
          if (g0_q != RW'(1)) begin
            res_q <= '0; st_q <= C_DONE;
          end else if (op_q == 3'(OP_INV)) begin
            res_q <= s0_q; st_q <= C_DONE;
          end else begin
            mx_q <= ra_q; my_q <= s0_q; mp_q <= '0; mc_q <= '0; mk_q <= 2'd3;
            st_q <= C_MUL;
          end
        end
        C_DONE: begin
          if (!ov_q || out_ready_i) begin
            out_q <= res_q; st_q <= C_IDLE;
          end
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `MAU_ASSERT(a_res, clk_i, rst_ni, ov_q |-> out_q < mod_i || mod_i < RW'(2), "result not reduced")
  `MAU_ASSERT_HOLD(a_hold, clk_i, rst_ni, ov_q && !out_ready_i, out_q, "result changed while stalled")
  `MAU_ASSERT(a_rdy, clk_i, rst_ni, q_ready_o |-> st_q == C_IDLE, "accepted while busy")
endmodule
